### sv/mbrc_pkg.sv
`timescale 1ns / 1ps
// Package for the Modbus RTU encoder reply checker.
// Holds the transfer types, status codes, frame constants and the CRC step.
// No dependencies.
package mbrc_pkg;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_TOO_SHORT  = 2'd1,
    STATUS_BAD_HEADER = 2'd2,
    STATUS_CRC_BAD    = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] raw_position;
    logic [15:0] angle_hundredths;
  } out_item_t;

  localparam logic [15:0] CRC_INIT          = 16'hFFFF;
  localparam logic [15:0] CRC_POLY          = 16'hA001;
  localparam logic [7:0]  DEVICE_ADDR_RESET = 8'h02;
  localparam logic [7:0]  FUNC_READ_HOLDING = 8'h03;
  localparam logic [7:0]  PAYLOAD_COUNT     = 8'h04;
  localparam logic [15:0] ANGLE_SCALE       = 16'd36000;

  localparam logic [3:0] POS_ADDR   = 4'd0;
  localparam logic [3:0] POS_FUNC   = 4'd1;
  localparam logic [3:0] POS_COUNT  = 4'd2;
  localparam logic [3:0] POS_WORD_H = 4'd3;
  localparam logic [3:0] POS_WORD_L = 4'd4;
  localparam logic [3:0] COUNT_MAX  = 4'd15;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

### sv/mbrc_out_skid.sv
`timescale 1ns / 1ps
// Two-entry output buffer for result items: output register plus skid entry.
// Depends on mbrc_pkg for out_item_t.
module mbrc_out_skid import mbrc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  out_item_t push_data,
  output logic      space,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic      main_valid_r, main_valid_nxt;
  logic      skid_valid_r, skid_valid_nxt;
  out_item_t main_r, main_nxt;
  out_item_t skid_r, skid_nxt;
  logic      main_free;

  assign main_free = !main_valid_r || out_ready;
  assign space     = !skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_data  = main_r;

  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    priority if (skid_valid_r) begin
      if (main_free) begin
        main_nxt       = skid_r;
        main_valid_nxt = 1'b1;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (main_free) begin
        main_nxt       = push_data;
        main_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = push_data;
        skid_valid_nxt = 1'b1;
      end
    end else if (main_valid_r && out_ready) begin
      main_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

endmodule

### sv/modbus_encoder_reply_checker.sv
`timescale 1ns / 1ps
// Modbus RTU encoder reply checker, top level.
// Depends on mbrc_pkg and mbrc_out_skid.
//
// Takes one reply byte per cycle (in_ready stays high while the two-entry
// output buffer has room) and gives one result per frame, registered in the
// output buffer when the byte marked last is transferred. The CRC-16 over a
// byte, eight shift steps, and the 16 by 16 angle multiply are combinational
// between the frame state registers and the output buffer. A frame shorter
// than MIN_FRAME_BYTES (5 to 16) reports too short; errors rank too short,
// bad header, CRC mismatch; an error result carries zero position and angle.
module modbus_encoder_reply_checker import mbrc_pkg::*; #(
  parameter int MIN_FRAME_BYTES = 9
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_we,
  input  logic [7:0] cfg_wdata,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam logic [4:0] MinBytes = 5'(MIN_FRAME_BYTES);

  logic [7:0]  dev_addr_r;
  logic [15:0] crc_r, crc_nxt;
  logic [3:0]  byte_cnt_r, byte_cnt_nxt;
  logic [7:0]  tail0_r, tail0_nxt;
  logic [7:0]  tail1_r, tail1_nxt;
  logic        hdr_good_r, hdr_good_nxt;
  logic [15:0] pos_r, pos_nxt;

  logic        in_fire;
  logic        space;
  logic [4:0]  total;
  logic [15:0] received;
  logic [31:0] product;
  status_t     status;
  out_item_t   result;

  assign in_ready = space;
  assign in_fire  = in_valid && in_ready;
  assign total    = {1'b0, byte_cnt_r} + 5'd1;
  assign received = {in_data.rx_byte, tail1_r};
  assign product  = pos_nxt * {16'h0000, ANGLE_SCALE};

  always_comb begin
    hdr_good_nxt = hdr_good_r;
    pos_nxt      = pos_r;
    crc_nxt      = crc_r;
    unique case (byte_cnt_r)
      POS_ADDR:   if (in_data.rx_byte != dev_addr_r) hdr_good_nxt = 1'b0;
      POS_FUNC:   if (in_data.rx_byte != FUNC_READ_HOLDING) hdr_good_nxt = 1'b0;
      POS_COUNT:  if (in_data.rx_byte != PAYLOAD_COUNT) hdr_good_nxt = 1'b0;
      POS_WORD_H: pos_nxt = {in_data.rx_byte, pos_r[7:0]};
      POS_WORD_L: pos_nxt = {pos_r[15:8], in_data.rx_byte};
      default:    ;
    endcase
    if (byte_cnt_r >= POS_COUNT) begin
      crc_nxt = crc_feed(crc_r, tail0_r);
    end
    tail0_nxt    = tail1_r;
    tail1_nxt    = in_data.rx_byte;
    byte_cnt_nxt = (byte_cnt_r == COUNT_MAX) ? byte_cnt_r : byte_cnt_r + 4'd1;
  end

  always_comb begin
    priority if (total < MinBytes) begin
      status = STATUS_TOO_SHORT;
    end else if (!hdr_good_nxt) begin
      status = STATUS_BAD_HEADER;
    end else if (received != crc_nxt) begin
      status = STATUS_CRC_BAD;
    end else begin
      status = STATUS_OK;
    end
    result.status = status;
    if (status == STATUS_OK) begin
      result.raw_position     = pos_nxt;
      result.angle_hundredths = product[31:16];
    end else begin
      result.raw_position     = 16'h0000;
      result.angle_hundredths = 16'h0000;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r <= DEVICE_ADDR_RESET;
    end else if (cfg_we) begin
      dev_addr_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r      <= CRC_INIT;
      byte_cnt_r <= POS_ADDR;
      tail0_r    <= 8'h00;
      tail1_r    <= 8'h00;
      hdr_good_r <= 1'b1;
      pos_r      <= 16'h0000;
    end else if (in_fire) begin
      if (in_data.last_byte) begin
        crc_r      <= CRC_INIT;
        byte_cnt_r <= POS_ADDR;
        tail0_r    <= 8'h00;
        tail1_r    <= 8'h00;
        hdr_good_r <= 1'b1;
        pos_r      <= 16'h0000;
      end else begin
        crc_r      <= crc_nxt;
        byte_cnt_r <= byte_cnt_nxt;
        tail0_r    <= tail0_nxt;
        tail1_r    <= tail1_nxt;
        hdr_good_r <= hdr_good_nxt;
        pos_r      <= pos_nxt;
      end
    end
  end

  mbrc_out_skid u_out_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_fire && in_data.last_byte),
    .push_data (result),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no result pending");

  a_error_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != STATUS_OK) |->
      (out_data.raw_position == 16'h0000 && out_data.angle_hundredths == 16'h0000))
    else $error("error result carries nonzero payload");

  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_data.last_byte) |=> (byte_cnt_r == POS_ADDR && crc_r == CRC_INIT))
    else $error("frame state not cleared after final byte");

  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.angle_hundredths < ANGLE_SCALE))
    else $error("angle out of range");

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// Testbench for modbus_encoder_reply_checker: drives reply frames, with good, corrupted,
// short and noise frames, at random pacing and predicts each frame status.
// Depends on mbrc_pkg and the checker RTL.
module tb_top import mbrc_pkg::*;;

  localparam int MIN_FRAME_BYTES = 9;
  localparam int TARGET_BYTES    = 2000;
  localparam int NUM_PHASES      = 6;

  typedef logic [7:0] frame_bytes_t[$];

  class reply_predictor #(int MIN_BYTES = 9);
    logic [7:0]  dev_addr;
    logic [15:0] crc_run;
    logic [3:0]  seen;
    logic [7:0]  held [2];
    bit          hdr_ok;
    logic [15:0] pos_word;
    out_item_t   expected_replies[$];

    function new();
      dev_addr = DEVICE_ADDR_RESET;
      clear_frame();
    endfunction

    static function logic [15:0] crc_step(logic [15:0] crc, logic [7:0] data);
      logic [15:0] c;
      c = crc;
      for (int i = 0; i < 8; i++) begin
        if (c[0] ^ data[i]) c = (c >> 1) ^ CRC_POLY;
        else c = c >> 1;
      end
      return c;
    endfunction

    function void clear_frame();
      crc_run  = CRC_INIT;
      seen     = '0;
      held[0]  = '0;
      held[1]  = '0;
      hdr_ok   = 1'b1;
      pos_word = '0;
    endfunction

    function void set_address(logic [7:0] addr);
      dev_addr = addr;
    endfunction

    function int pending();
      return expected_replies.size();
    endfunction

    function void note_input(in_item_t item);
      logic [3:0]  idx;
      int          total;
      logic [15:0] received;
      out_item_t   r;
      idx = seen;
      case (idx)
        POS_ADDR:   if (item.rx_byte != dev_addr) hdr_ok = 1'b0;
        POS_FUNC:   if (item.rx_byte != FUNC_READ_HOLDING) hdr_ok = 1'b0;
        POS_COUNT:  if (item.rx_byte != PAYLOAD_COUNT) hdr_ok = 1'b0;
        POS_WORD_H: pos_word[15:8] = item.rx_byte;
        POS_WORD_L: pos_word[7:0] = item.rx_byte;
        default: ;
      endcase
      // release the byte that can no longer be part of the trailing CRC
      if (idx >= 2) crc_run = crc_step(crc_run, held[0]);
      held[0] = held[1];
      held[1] = item.rx_byte;
      total = int'(idx) + 1;
      if (seen != COUNT_MAX) seen = seen + 4'd1;
      if (!item.last_byte) return;
      received = {held[1], held[0]};
      r = '0;
      if (total < MIN_BYTES) r.status = STATUS_TOO_SHORT;
      else if (!hdr_ok) r.status = STATUS_BAD_HEADER;
      else if (received != crc_run) r.status = STATUS_CRC_BAD;
      else begin
        r.status = STATUS_OK;
        r.raw_position = pos_word;
        r.angle_hundredths = 16'((32'(pos_word) * 32'(ANGLE_SCALE)) >> 16);
      end
      expected_replies.push_back(r);
      clear_frame();
    endfunction

    function string check_result(out_item_t got);
      out_item_t want;
      string     msg;
      if (expected_replies.size() == 0)
        return $sformatf("unexpected result status=%0d raw=%h angle=%0d",
                         got.status, got.raw_position, got.angle_hundredths);
      want = expected_replies.pop_front();
      msg = "";
      if (got.status !== want.status)
        msg = {msg, $sformatf(" status got %0d want %0d", got.status, want.status)};
      if (got.raw_position !== want.raw_position)
        msg = {msg, $sformatf(" raw_position got %h want %h",
                              got.raw_position, want.raw_position)};
      if (got.angle_hundredths !== want.angle_hundredths)
        msg = {msg, $sformatf(" angle_hundredths got %0d want %0d",
                              got.angle_hundredths, want.angle_hundredths)};
      if (msg == "") return "";
      return {"result mismatch:", msg};
    endfunction
  endclass

  typedef reply_predictor #(MIN_FRAME_BYTES) predictor_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      cfg_we = 1'b0;
  logic [7:0] cfg_wdata = '0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  predictor_t reply_pred = new();
  int  err_count = 0;
  int  sent_bytes = 0;
  bit  in_idle = 1'b1;
  bit  out_idle = 1'b1;

  modbus_encoder_reply_checker #(
    .MIN_FRAME_BYTES(MIN_FRAME_BYTES)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  always #10 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("%0t: %s", $time, msg);
    err_count++;
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = in_idle ? $urandom_range(0, 18) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data  <= '{rx_byte: b, last_byte: last};
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    reply_pred.note_input('{rx_byte: b, last_byte: last});
    sent_bytes++;
  endtask

  task automatic send_frame(input frame_bytes_t bytes);
    foreach (bytes[i]) send_byte(bytes[i], i == bytes.size() - 1);
  endtask

  task automatic write_address(input logic [7:0] addr);
    in_valid <= 1'b0;
    while (reply_pred.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= addr;
    @(posedge clk);
    cfg_we <= 1'b0;
    reply_pred.set_address(addr);
  endtask

  function automatic frame_bytes_t with_crc(input frame_bytes_t body);
    logic [15:0] crc;
    crc = CRC_INIT;
    foreach (body[i]) crc = crc_feed(crc, body[i]);
    body.push_back(crc[7:0]);
    body.push_back(crc[15:8]);
    return body;
  endfunction

  function automatic frame_bytes_t good_frame(input logic [7:0] addr, input logic [15:0] pos,
                                              input int n);
    frame_bytes_t body;
    body = '{addr, FUNC_READ_HOLDING, PAYLOAD_COUNT, pos[15:8], pos[7:0]};
    for (int i = 7; i < n; i++) body.push_back(8'($urandom_range(0, 255)));
    return with_crc(body);
  endfunction

  function automatic logic [15:0] pick_position();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return 16'h0000;
    if (sel == 1) return 16'hFFFF;
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic int pick_length();
    return ($urandom_range(0, 4) == 0) ? $urandom_range(10, 20) : MIN_FRAME_BYTES;
  endfunction

  task automatic send_random_frame();
    frame_bytes_t f;
    int kind, at, n;
    kind = $urandom_range(0, 99);
    f = good_frame(reply_pred.dev_addr, pick_position(), pick_length());
    if (kind < 55) begin
      send_frame(f);
    end else if (kind < 65) begin
      at = $urandom_range(0, f.size() - 1);
      f[at] = f[at] ^ (8'h01 << $urandom_range(0, 7));
      send_frame(f);
    end else if (kind < 75) begin
      f = f[0:$urandom_range(0, MIN_FRAME_BYTES - 2)];
      send_frame(f);
    end else if (kind < 85) begin
      f = f[0:f.size() - 3];
      at = $urandom_range(0, 2);
      f[at] = f[at] ^ (8'h01 << $urandom_range(0, 7));
      send_frame(with_crc(f));
    end else begin
      n = $urandom_range(1, 20);
      f = {};
      repeat (n) f.push_back(8'($urandom_range(0, 255)));
      send_frame(f);
    end
  endtask

  initial begin : limit_guard
    #20_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : result_sink
    out_item_t got;
    string     msg;
    int        stall;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = out_idle ? $urandom_range(0, 18) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      got = out_data;
      msg = reply_pred.check_result(got);
      if (msg != "") report_mismatch(msg);
    end
  end

  initial begin : stimulus
    frame_bytes_t f;
    logic [7:0] addr_plan [NUM_PHASES];
    addr_plan = '{DEVICE_ADDR_RESET, 8'h00, 8'hFF, 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), DEVICE_ADDR_RESET};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // too short wins over a bad header
    send_frame('{8'hFF});
    send_frame(good_frame(DEVICE_ADDR_RESET, 16'hFFFF, MIN_FRAME_BYTES));
    // bad header wins over a CRC mismatch
    f = good_frame(DEVICE_ADDR_RESET, 16'h0000, MIN_FRAME_BYTES);
    f[1] = 8'h00;
    f[f.size() - 1] = ~f[f.size() - 1];
    send_frame(f);

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) write_address(addr_plan[p]);
      in_idle  = $urandom_range(0, 3) != 0;
      out_idle = $urandom_range(0, 3) != 0;
      while (sent_bytes < (p + 1) * TARGET_BYTES / NUM_PHASES) begin
        if ($urandom_range(0, 19) == 0) begin
          in_idle  = $urandom_range(0, 2) != 0;
          out_idle = $urandom_range(0, 2) != 0;
        end
        send_random_frame();
      end
    end

    in_valid <= 1'b0;
    while (reply_pred.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (err_count == 0 && reply_pred.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
